// ----- hw/rtl/frame_integrity_monitor_core_macros.svh -----
// ----------------------------------------------------------------------------
// Frame integrity monitor assertion macros
// Shared concurrent assertion forms for the monitor's checker.
// ----------------------------------------------------------------------------
`ifndef FRAME_INTEGRITY_MONITOR_CORE_MACROS_SVH
`define FRAME_INTEGRITY_MONITOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FIM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("frame integrity monitor: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define FIM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("frame integrity monitor: assertion failed");

`endif

// ----- hw/rtl/fim_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame integrity monitor package
// Sizes, constants, codes and shared types of the frame integrity monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package fim_pkg;

    // Sizing
    localparam int unsigned HISTORY_DEPTH = 100;
    localparam int unsigned SCAN_LIMIT    = 1024;
    localparam int unsigned CHECK_PERIOD  = 100;
    localparam int unsigned CNT_W         = $clog2(SCAN_LIMIT + 1);
    localparam int unsigned GAP_SUM_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned PERIOD_W      = $clog2(CHECK_PERIOD);

    // Hash and thresholds
    localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME    = 32'd16777619;
    localparam logic [31:0] GAP_LIMIT_MS = 32'd200;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
    localparam logic [7:0]  CHAR_SPACE   = 8'd32;
    localparam logic [7:0]  CHAR_TILDE   = 8'd126;
    localparam int unsigned MIN_VISIBLE  = 10;
    localparam int unsigned MAX_GAPS     = 5;

    // Port widths
    localparam int unsigned S_TDATA_W   = 40;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MONITOR_ENABLE = 8'd0,
        REG_SLOW_THRESHOLD = 8'd1
    } cfg_reg_t;

    // Input item kind
    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_END  = 1'b1
    } cmd_t;

    // Control from the frame logic to the byte scanner
    typedef struct packed {
        logic byte_en;
        logic frame_end;
    } scan_ctrl_t;

    // Running statistics of the frame in progress
    typedef struct packed {
        logic [31:0]      hash;
        logic [CNT_W-1:0] scanned;
        logic [CNT_W-1:0] visible;
        logic [CNT_W-1:0] printable;
    } scan_stats_t;

    // Result item, lowest field last so that frame_hash sits in the low bits
    typedef struct packed {
        logic        pad;
        logic        gaps_high;
        logic        slow_rate_high;
        logic        dup_rate_high;
        logic        check_done;
        logic [31:0] slow_total;
        logic [31:0] duplicate_total;
        logic [31:0] frame_total;
        logic [31:0] interval_ms;
        logic        slow_flag;
        logic        duplicate_flag;
        logic        empty_flag;
        logic [31:0] frame_hash;
    } result_t;

    localparam int unsigned M_TDATA_W = $bits(result_t);

endpackage

`default_nettype wire

// ----- hw/rtl/fim_frame_scan.sv -----
// ----------------------------------------------------------------------------
// Frame byte scanner
// FNV-1a hash and visible/printable byte counts over the head of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module fim_frame_scan
    import fim_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire scan_ctrl_t  ctrl,
    input  wire logic [7:0]  byte_value,
    output scan_stats_t      stats
);

    logic [31:0]      hash_reg,      hash_next;
    logic [CNT_W-1:0] scanned_reg,   scanned_next;
    logic [CNT_W-1:0] visible_reg,   visible_next;
    logic [CNT_W-1:0] printable_reg, printable_next;
    logic             in_scan;
    logic             is_printable;

    assign in_scan      = scanned_reg < CNT_W'(SCAN_LIMIT);
    assign is_printable = (byte_value >= CHAR_SPACE) && (byte_value <= CHAR_TILDE);

    // Fold in one byte, or restart at frame end
    always_comb begin
        hash_next      = hash_reg;
        scanned_next   = scanned_reg;
        visible_next   = visible_reg;
        printable_next = printable_reg;
        if (ctrl.frame_end) begin
            hash_next      = FNV_BASIS;
            scanned_next   = '0;
            visible_next   = '0;
            printable_next = '0;
        end else if (ctrl.byte_en && in_scan) begin
            hash_next    = (hash_reg ^ {24'd0, byte_value}) * FNV_PRIME;
            scanned_next = scanned_reg + CNT_W'(1);
            if (is_printable) begin
                printable_next = printable_reg + CNT_W'(1);
                if (byte_value != CHAR_SPACE) begin
                    visible_next = visible_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg      <= FNV_BASIS;
            scanned_reg   <= '0;
            visible_reg   <= '0;
            printable_reg <= '0;
        end else begin
            hash_reg      <= hash_next;
            scanned_reg   <= scanned_next;
            visible_reg   <= visible_next;
            printable_reg <= printable_next;
        end
    end

    assign stats.hash      = hash_reg;
    assign stats.scanned   = scanned_reg;
    assign stats.visible   = visible_reg;
    assign stats.printable = printable_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/frame_integrity_monitor_core.sv -----
// ----------------------------------------------------------------------------
// Frame integrity monitor core
// Per-frame hash, blank, duplicate and timing checks with periodic rate checks.
// ----------------------------------------------------------------------------
// Frame bytes (tuser low) and end-of-frame items (tuser high, timestamp in
// tdata) stream in at one item per clock while the output slot is free. Each
// item passes an input register and is processed once the output slot is
// free; an end-of-frame item's result is then loaded into the output register.
// The sustained rate of one item per cycle is set by the running-hash
// register, whose xor-and-multiply update is a single combinational step.
// Byte items produce no result. While monitor_enable is zero every item is
// taken and dropped and a partly received frame is held. Only the first 1024
// bytes of a frame are hashed and counted. The timing-gap history is a shift
// line of per-frame flags, cleared by reset at once.
`default_nettype none

module frame_integrity_monitor_core
    import fim_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // [7:0] byte_value, [39:8] time_ms
    input  wire logic [0:0]             s_tuser,   // [0] cmd
    // Result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,   // [31:0] frame_hash, [32] empty_flag,
                                                   // [33] duplicate_flag, [34] slow_flag,
                                                   // [66:35] interval_ms,
                                                   // [98:67] frame_total,
                                                   // [130:99] duplicate_total,
                                                   // [162:131] slow_total,
                                                   // [163] check_done,
                                                   // [164] dup_rate_high,
                                                   // [165] slow_rate_high,
                                                   // [166] gaps_high, [167] zero
    // Configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned EMPTY_W = CNT_W + 5;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

    // Configuration registers
    logic        enable_reg;
    logic [15:0] slow_thr_reg;

    // Input register
    logic        in_valid_reg;
    cmd_t        in_cmd_reg;
    logic [7:0]  in_byte_reg;
    logic [31:0] in_time_reg;

    // Frame history state
    logic [31:0]              frames_reg,   frames_next;
    logic [31:0]              dup_cnt_reg,  dup_cnt_next;
    logic [31:0]              slow_cnt_reg, slow_cnt_next;
    logic [31:0]              prev_hash_reg;
    logic [31:0]              prev_time_reg;
    logic [HISTORY_DEPTH-1:0] gap_hist_reg;
    logic [GAP_SUM_W-1:0]     gap_sum_reg,  gap_sum_next;
    logic [PERIOD_W-1:0]      period_reg,   period_next;

    // Output register
    logic    out_valid_reg;
    result_t result_reg;

    // Handshake and strobes
    logic        out_free;
    logic        advance;
    logic        work;
    scan_ctrl_t  scan_ctrl;
    scan_stats_t stats;

    // Frame-end evaluation
    logic                 first_frame;
    logic [31:0]          hash;
    logic [31:0]          interval;
    logic [CNT_W-1:0]     blanks;
    logic [EMPTY_W-1:0]   blanks_x20;
    logic [EMPTY_W-1:0]   printable_x19;
    logic                 empty;
    logic                 dup;
    logic                 slow;
    logic                 gap;
    logic [GAP_SUM_W-1:0] newest_gaps;
    logic                 check;
    logic                 dup_high;
    logic                 slow_high;
    logic                 gaps_high;
    logic [32:0]          dup_x2;
    logic [36:0]          slow_x20;
    result_t              result_next;

    // Stream handshake: a transfer moves on whenever the output slot is free
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign work      = advance && enable_reg;

    assign scan_ctrl.byte_en   = work && (in_cmd_reg == CMD_BYTE);
    assign scan_ctrl.frame_end = work && (in_cmd_reg == CMD_END);

    fim_frame_scan u_frame_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (scan_ctrl),
        .byte_value (in_byte_reg),
        .stats      (stats)
    );

    // Per-frame flags
    always_comb begin
        first_frame   = (frames_reg == 32'd0);
        hash          = (stats.scanned == '0) ? 32'd0 : stats.hash;
        interval      = first_frame ? 32'd0 : in_time_reg - prev_time_reg;
        blanks        = stats.printable - stats.visible;
        blanks_x20    = EMPTY_W'(blanks) * EMPTY_W'(20);
        printable_x19 = EMPTY_W'(stats.printable) * EMPTY_W'(19);
        empty         = (stats.visible < CNT_W'(MIN_VISIBLE)) || (blanks_x20 > printable_x19);
        dup           = !first_frame && (hash == prev_hash_reg);
        slow          = interval > {16'd0, slow_thr_reg};
        gap           = interval > GAP_LIMIT_MS;
    end

    // Totals, gap history and check period
    always_comb begin
        dup_cnt_next  = dup  ? sat_inc(dup_cnt_reg)  : dup_cnt_reg;
        slow_cnt_next = slow ? sat_inc(slow_cnt_reg) : slow_cnt_reg;
        gap_sum_next  = gap_sum_reg - GAP_SUM_W'(gap_hist_reg[HISTORY_DEPTH-1])
                        + GAP_SUM_W'(gap);
        newest_gaps   = gap_sum_next - GAP_SUM_W'(gap_hist_reg[HISTORY_DEPTH-2]);
        frames_next   = frames_reg;
        period_next   = period_reg;
        if (frames_reg != COUNT_MAX) begin
            frames_next = frames_reg + 32'd1;
            period_next = (period_reg == PERIOD_W'(CHECK_PERIOD - 1)) ? '0
                          : period_reg + PERIOD_W'(1);
        end
        check     = (period_next == '0);
        dup_x2    = {dup_cnt_next, 1'b0};
        slow_x20  = {1'b0, slow_cnt_next, 4'd0} + {3'd0, slow_cnt_next, 2'd0};
        dup_high  = check && (dup_x2 > {1'b0, frames_next});
        slow_high = check && (slow_x20 > {5'd0, frames_next});
        gaps_high = check && (frames_next >= 32'(HISTORY_DEPTH))
                    && (newest_gaps > GAP_SUM_W'(MAX_GAPS));
    end

    // Assemble the result item
    always_comb begin
        result_next.pad             = 1'b0;
        result_next.gaps_high       = gaps_high;
        result_next.slow_rate_high  = slow_high;
        result_next.dup_rate_high   = dup_high;
        result_next.check_done      = check;
        result_next.slow_total      = slow_cnt_next;
        result_next.duplicate_total = dup_cnt_next;
        result_next.frame_total     = frames_next;
        result_next.interval_ms     = interval;
        result_next.slow_flag       = slow;
        result_next.duplicate_flag  = dup;
        result_next.empty_flag      = empty;
        result_next.frame_hash      = hash;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            slow_thr_reg <= 16'd100;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MONITOR_ENABLE: enable_reg   <= cfg_data[0];
                REG_SLOW_THRESHOLD: slow_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: load on transfer, drop once processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= cmd_t'(s_tuser[0]);
            in_byte_reg <= s_tdata[7:0];
            in_time_reg <= s_tdata[39:8];
        end
    end

    // Frame history: advance on each recorded frame end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg    <= '0;
            dup_cnt_reg   <= '0;
            slow_cnt_reg  <= '0;
            prev_hash_reg <= '0;
            prev_time_reg <= '0;
            gap_hist_reg  <= '0;
            gap_sum_reg   <= '0;
            period_reg    <= '0;
        end else if (scan_ctrl.frame_end) begin
            frames_reg    <= frames_next;
            dup_cnt_reg   <= dup_cnt_next;
            slow_cnt_reg  <= slow_cnt_next;
            prev_hash_reg <= hash;
            prev_time_reg <= in_time_reg;
            gap_hist_reg  <= {gap_hist_reg[HISTORY_DEPTH-2:0], gap};
            gap_sum_reg   <= gap_sum_next;
            period_reg    <= period_next;
        end
    end

    // Output register: hold until the result transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (scan_ctrl.frame_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_ctrl.frame_end) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fim_checker.sv -----
// ----------------------------------------------------------------------------
// Frame integrity monitor checker
// Port-level assertions on the result stream, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_integrity_monitor_core_macros.svh"

module fim_checker
    import fim_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    result_t     res;
    logic        out_xfer;
    logic        seen_reg;
    logic [31:0] prev_total_reg;
    logic [31:0] prev_dup_reg;
    logic [31:0] exp_total;

    assign res       = result_t'(m_tdata);
    assign out_xfer  = m_tvalid && m_tready;
    assign exp_total = (prev_total_reg == COUNT_MAX) ? COUNT_MAX : prev_total_reg + 32'd1;

    // Track the totals of the last result transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (out_xfer) begin
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_xfer) begin
            prev_total_reg <= res.frame_total;
            prev_dup_reg   <= res.duplicate_total;
        end
    end

    // A stalled result holds
    `FIM_ASSERT_NXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata))

    // Each result counts exactly one more frame, until the total saturates
    `FIM_ASSERT_IMP(a_frame_total_step, aclk, aresetn, out_xfer && seen_reg,
                    res.frame_total == exp_total)

    // A flagged duplicate advances the duplicate total
    `FIM_ASSERT_IMP(a_dup_total_step, aclk, aresetn,
                    out_xfer && seen_reg && res.duplicate_flag && (prev_dup_reg != COUNT_MAX),
                    res.duplicate_total == prev_dup_reg + 32'd1)

endmodule

bind frame_integrity_monitor_core fim_checker u_fim_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
